FILE: design/mta_pkg.sv
// Package for the multi-slot alarm timer.
// Holds widths, request codes, payload and slot types, and the control structs.
// No dependencies.
package mta_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int ID_W          = 8;
  localparam int DELAY_W       = 23;

  // request type codes
  localparam logic REQ_PROGRAM = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [ID_W-1:0]    msg_id;
    logic               periodic;
    logic [DELAY_W-1:0] delay_ticks;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] fired_id;
    logic            last;
  } res_t;

  // one table entry as kept in the slot RAM
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               periodic;
    logic [DELAY_W-1:0] reload;
    logic [DELAY_W-1:0] countdown;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_DRAIN  = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic idle;
    logic scan;
    logic commit;
    logic drain;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_valid;
    logic is_tick;
    logic scan_done;
    logic drain_done;
  } sts_t;

endpackage

FILE: design/mta_req_if.sv
// Request channel of the alarm timer: valid, ready and one request payload.
// Depends on mta_pkg.
interface mta_req_if;
  import mta_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/mta_res_if.sv
// Result channel of the alarm timer: valid, ready and one expiry payload.
// Depends on mta_pkg.
interface mta_res_if;
  import mta_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/mta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/mta_ctrl.sv
// Controller of the alarm timer: sequences accept, slot scan, commit and drain.
// Depends on mta_pkg.
module mta_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  mta_pkg::sts_t sts,
  output mta_pkg::cmd_t cmd
);
  import mta_pkg::*;

  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sts.req_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = sts.is_tick ? S_DRAIN : S_COMMIT;
      end
      S_COMMIT: state_next = S_IDLE;
      S_DRAIN: begin
        if (sts.drain_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands
  always_comb begin
    cmd.idle   = (state == S_IDLE);
    cmd.scan   = (state == S_SCAN);
    cmd.commit = (state == S_COMMIT);
    cmd.drain  = (state == S_DRAIN);
  end

endmodule

FILE: design/mta_datapath.sv
// Datapath of the alarm timer: request register, active flags, slot RAM,
// scan index, match tracking, pending expiry and output register.
// Depends on mta_pkg, mta_req_if, mta_res_if and mta_ram.
module mta_datapath #(
  parameter int NUM_SLOTS = mta_pkg::NUM_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mta_req_if.sink       req,
  mta_res_if.source     res,
  input  mta_pkg::cmd_t cmd,
  output mta_pkg::sts_t sts
);
  import mta_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int NW = $clog2(MAX_RESULTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  req_t                 rq;
  logic [IW-1:0]        idx;
  logic [NUM_SLOTS-1:0] active;
  logic                 match_hit, free_hit;
  logic [IW-1:0]        match_idx, free_idx;
  logic                 pend_valid;
  logic [ID_W-1:0]      pend_id;
  logic [NW-1:0]        n_rep;
  logic                 res_valid;
  res_t                 res_data;

  slot_t                rd_slot, wr_slot;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr, rd_addr;

  logic accept, is_tick, slot_on, expire, report, out_free;
  logic stall, advance, at_last, push_scan, push_drain, has_delay;

  mta_ram #(.WIDTH($bits(slot_t)), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_slot),
    .rd_addr (rd_addr),
    .rd_data (rd_slot)
  );

  // scan decisions for the slot at idx
  always_comb begin
    accept     = req.valid && cmd.idle;
    is_tick    = (rq.req_type == REQ_TICK);
    has_delay  = (rq.delay_ticks != '0);
    slot_on    = active[idx];
    expire     = slot_on && (rd_slot.countdown <= DELAY_W'(1));
    report     = expire && (n_rep < NW'(MAX_RESULTS));
    out_free   = !res_valid || res.ready;
    stall      = cmd.scan && is_tick && report && pend_valid && !out_free;
    advance    = cmd.scan && !stall;
    at_last    = (idx == LAST_IDX);
    push_scan  = cmd.scan && is_tick && report && pend_valid && out_free;
    push_drain = cmd.drain && pend_valid && out_free;
  end

  // read address runs one slot ahead while the scan advances
  always_comb begin
    rd_addr = '0;
    if (cmd.scan) begin
      rd_addr = (advance && !at_last) ? idx + IW'(1) : idx;
    end
  end

  // table writes: countdown update on a tick, slot load on commit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_slot = rd_slot;
    if (cmd.scan && is_tick && advance && slot_on) begin
      wr_en = 1'b1;
      if (!expire) begin
        wr_slot.countdown = rd_slot.countdown - DELAY_W'(1);
      end else if (rd_slot.periodic) begin
        wr_slot.countdown = rd_slot.reload;
      end else begin
        wr_slot.countdown = '0;
      end
    end else if (cmd.commit) begin
      wr_slot.id        = rq.msg_id;
      wr_slot.periodic  = rq.periodic;
      wr_slot.reload    = rq.delay_ticks;
      wr_slot.countdown = rq.delay_ticks;
      wr_addr           = match_hit ? match_idx : free_idx;
      wr_en             = has_delay && (match_hit || free_hit);
    end
  end

  // active flags
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.scan && is_tick && advance && expire && !rd_slot.periodic) begin
      active[idx] <= 1'b0;
    end else if (cmd.commit) begin
      if (match_hit) begin
        if (!has_delay) active[match_idx] <= 1'b0;
      end else if (has_delay && free_hit) begin
        active[free_idx] <= 1'b1;
      end
    end
  end

  // request capture, scan index and search results
  always_ff @(posedge clk) begin
    if (accept) begin
      rq        <= req.data;
      idx       <= '0;
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
    end else if (advance) begin
      if (!at_last) idx <= idx + IW'(1);
      if (!is_tick) begin
        if (slot_on && (rd_slot.id == rq.msg_id) && !match_hit) begin
          match_hit <= 1'b1;
          match_idx <= idx;
        end
        if (!slot_on && !free_hit) begin
          free_hit <= 1'b1;
          free_idx <= idx;
        end
      end
    end
  end

  // pending expiry: held back until it is known whether it is the last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      n_rep      <= '0;
    end else if (accept) begin
      n_rep <= '0;
    end else if (advance && is_tick && report) begin
      pend_valid <= 1'b1;
      pend_id    <= rd_slot.id;
      n_rep      <= n_rep + NW'(1);
    end else if (push_drain) begin
      pend_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push_scan || push_drain) begin
      res_valid         <= 1'b1;
      res_data.fired_id <= pend_id;
      res_data.last     <= push_drain;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign req.ready = cmd.idle;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  always_comb begin
    sts.req_valid  = req.valid;
    sts.is_tick    = is_tick;
    sts.scan_done  = advance && at_last;
    sts.drain_done = !pend_valid || out_free;
  end

  // checks
  a_nrep_bound: assert property (@(posedge clk) disable iff (rst)
    n_rep <= NW'(MAX_RESULTS))
    else $error("reported count beyond result limit");

  a_pend_tick: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (rq.req_type == REQ_TICK))
    else $error("pending expiry outside a tick");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    push_drain |=> (res.valid && res.data.last))
    else $error("final expiry of a tick not marked last");

  a_wr_phase: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (cmd.scan || cmd.commit))
    else $error("slot table written outside scan or commit");

endmodule

FILE: design/multi_slot_alarm_timer.sv
// Top level of the multi-slot alarm timer.
// Depends on mta_pkg, mta_req_if, mta_res_if, mta_ctrl and mta_datapath.
//
// A table of NUM_SLOTS alarm slots. A program request (req_type 0) with a
// nonzero delay updates the active slot holding the same msg_id, or else
// fills the lowest free slot (dropped when the table is full); a zero delay
// cancels the matching slot. A tick (req_type 1) counts every active slot
// down and reports each expiring id in ascending slot order, at most eight
// per tick, with last set on the final one; one-shot slots are freed and
// periodic ones reload. Each request passes from its acceptance through the
// accepting idle state, a scan that visits one slot per cycle through the read
// port of the slot RAM, held while an expiry waits on the result channel,
// and a commit or drain state; ready returns once the controller is back
// in idle. A tick takes longer while the result channel holds back ready.
// Active flags are flip-flops cleared by reset, so no clearing pass follows
// reset.
module multi_slot_alarm_timer #(
  parameter int NUM_SLOTS = mta_pkg::NUM_SLOTS_DEF
) (
  input logic       clk,
  input logic       rst,
  mta_req_if.sink   req,
  mta_res_if.source res
);
  import mta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mta_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  mta_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

FILE: sim/multi_slot_alarm_timer_tb.sv
// Testbench for the multi-slot alarm timer: drives program, cancel and tick requests and
// checks every reported expiry against a slot-table predictor kept inside the bench.
// Depends on mta_pkg, mta_req_if, mta_res_if and multi_slot_alarm_timer.
module multi_slot_alarm_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mta_pkg::*;

  localparam int NUM_SLOTS  = NUM_SLOTS_DEF;
  localparam int HOLD_LONG  = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int END_CYCLES = 30;

  logic clk = 1'b0;
  logic rst;

  mta_req_if req_ch();
  mta_res_if res_ch();

  multi_slot_alarm_timer #(.NUM_SLOTS(NUM_SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // requests waiting to be offered, expiries waiting to be reported
  req_t pending_reqs[$];
  res_t expected_fires[$];

  // alarm table as the block should hold it
  logic               alarm_on     [NUM_SLOTS] = '{default: 1'b0};
  logic [ID_W-1:0]    alarm_id     [NUM_SLOTS] = '{default: '0};
  logic               alarm_per    [NUM_SLOTS] = '{default: 1'b0};
  logic [DELAY_W-1:0] alarm_reload [NUM_SLOTS] = '{default: '0};
  logic [DELAY_W-1:0] alarm_count  [NUM_SLOTS] = '{default: '0};

  int send_idle_pct = 25;
  int recv_idle_pct = 50;
  int n_accepted    = 0;
  int n_ticks       = 0;
  int n_programs    = 0;
  int n_fires       = 0;
  int errors        = 0;
  int idle_cycles;
  int hold_left;
  bit long_hold_req = 1'b0;
  bit long_hold_done;

  // apply one accepted request to the table and queue the expiries it causes
  function automatic void predict_request(req_t r);
    logic [ID_W-1:0] ids[$];
    res_t f;
    int hit;
    int k;
    if (r.req_type == REQ_TICK) begin
      n_ticks++;
      for (k = 0; k < NUM_SLOTS; k++) begin
        if (!alarm_on[k]) continue;
        if (alarm_count[k] > 1) begin
          alarm_count[k] = alarm_count[k] - 1'b1;
          continue;
        end
        if (ids.size() < MAX_RESULTS) ids.push_back(alarm_id[k]);
        if (alarm_per[k]) begin
          alarm_count[k] = alarm_reload[k];
        end else begin
          alarm_on[k]    = 1'b0;
          alarm_count[k] = '0;
        end
      end
      for (k = 0; k < ids.size(); k++) begin
        f.fired_id = ids[k];
        f.last     = (k == ids.size() - 1);
        expected_fires.push_back(f);
      end
    end else begin
      n_programs++;
      hit = -1;
      for (k = 0; k < NUM_SLOTS; k++)
        if (hit < 0 && alarm_on[k] && alarm_id[k] == r.msg_id) hit = k;
      // no match: a nonzero delay takes the lowest free slot, a cancel does nothing
      if (hit < 0 && r.delay_ticks != '0) begin
        for (k = 0; k < NUM_SLOTS; k++)
          if (hit < 0 && !alarm_on[k]) hit = k;
        if (hit >= 0) begin
          alarm_on[hit] = 1'b1;
          alarm_id[hit] = r.msg_id;
        end
      end
      if (hit >= 0) begin
        if (r.delay_ticks == '0) begin
          alarm_on[hit] = 1'b0;
        end else begin
          alarm_per[hit]    = r.periodic;
          alarm_reload[hit] = r.delay_ticks;
          alarm_count[hit]  = r.delay_ticks;
        end
      end
    end
  endfunction

  function automatic req_t prog_req(logic [ID_W-1:0] id, logic per, logic [DELAY_W-1:0] d);
    req_t r;
    r.req_type    = REQ_PROGRAM;
    r.msg_id      = id;
    r.periodic    = per;
    r.delay_ticks = d;
    return r;
  endfunction

  // tick fields carry noise, the block ignores them
  function automatic req_t tick_req(logic [ID_W-1:0] id, logic per, logic [DELAY_W-1:0] d);
    req_t r;
    r = prog_req(id, per, d);
    r.req_type = REQ_TICK;
    return r;
  endfunction

  // mostly small ids and short delays so slots collide, fill up and fire often
  function automatic req_t random_req();
    int sel;
    int dsel;
    logic [ID_W-1:0] id;
    logic [DELAY_W-1:0] d;
    sel = $urandom_range(0, 99);
    if (sel < 45) return tick_req(ID_W'($urandom), 1'($urandom), DELAY_W'($urandom));
    dsel = $urandom_range(0, 99);
    if (dsel < 12)      d = '0;
    else if (dsel < 85) d = DELAY_W'($urandom_range(1, 6));
    else if (dsel < 95) d = DELAY_W'($urandom_range(7, 40));
    else                d = DELAY_W'($urandom_range(1, 23'h7FFFFF));
    if ($urandom_range(0, 9) == 0) begin
      // stray id: one-shot and short so it never clogs the table
      id = ID_W'($urandom_range(0, 255));
      return prog_req(id, 1'b0, DELAY_W'($urandom_range(1, 4)));
    end
    id = ID_W'($urandom_range(0, 11));
    return prog_req(id, 1'($urandom_range(0, 1)), d);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_request(req_ch.data);
        n_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_ch.data  <= pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    res_t exp_f;
    if (rst) begin
      res_ch.ready   <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        n_fires++;
        if (expected_fires.size() == 0) begin
          errors++;
          $display("%0t: unexpected expiry: expected none, actual id %02h last %0b",
                   $time, res_ch.data.fired_id, res_ch.data.last);
        end else begin
          exp_f = expected_fires.pop_front();
          if (res_ch.data.fired_id !== exp_f.fired_id) begin
            errors++;
            $display("%0t: fired_id mismatch: expected %02h, actual %02h",
                     $time, exp_f.fired_id, res_ch.data.fired_id);
          end
          if (res_ch.data.last !== exp_f.last) begin
            errors++;
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, exp_f.last, res_ch.data.last);
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        hold_left      <= HOLD_LONG;
        long_hold_done <= 1'b1;
        res_ch.ready   <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int k;
    int base;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme ids and delays, reload, overwrite, cancels, full table
    pending_reqs.push_back(prog_req(8'h00, 1'b0, 23'd1));
    pending_reqs.push_back(tick_req(8'h00, 1'b0, 23'd0));
    pending_reqs.push_back(prog_req(8'hFF, 1'b1, 23'd2));
    pending_reqs.push_back(tick_req(8'h00, 1'b0, 23'd0));
    pending_reqs.push_back(tick_req(8'h00, 1'b0, 23'd0));
    pending_reqs.push_back(prog_req(8'h55, 1'b0, 23'd0));           // cancel, no such id
    pending_reqs.push_back(prog_req(8'hAA, 1'b1, 23'h7FFFFF));
    pending_reqs.push_back(prog_req(8'hAA, 1'b0, 23'd3));           // same id overwrites
    for (k = 1; k <= 6; k++)
      pending_reqs.push_back(prog_req(ID_W'(k), k[0], 23'd1));
    pending_reqs.push_back(prog_req(8'h77, 1'b1, 23'd1));           // table full, dropped
    pending_reqs.push_back(tick_req(8'hFF, 1'b1, 23'h7FFFFF));
    pending_reqs.push_back(tick_req(8'h00, 1'b0, 23'd0));
    pending_reqs.push_back(prog_req(8'hFF, 1'b0, 23'd0));           // cancel
    pending_reqs.push_back(tick_req(8'h00, 1'b0, 23'd0));
    pending_reqs.push_back(tick_req(8'h00, 1'b0, 23'd0));
    pending_reqs.push_back(prog_req(8'h03, 1'b0, 23'd0));
    pending_reqs.push_back(tick_req(8'h00, 1'b0, 23'd0));
    for (k = 0; k < 85; k++) pending_reqs.push_back(random_req());
    while (pending_reqs.size() > 0 || req_ch.valid) @(posedge clk);

    // receiver idles less than the sender
    send_idle_pct = 50;
    recv_idle_pct = 25;
    for (k = 0; k < 107; k++) pending_reqs.push_back(random_req());
    while (pending_reqs.size() > 0 || req_ch.valid) @(posedge clk);

    // full rate, with one long receiver stall partway through
    send_idle_pct = 0;
    recv_idle_pct = 0;
    base = n_accepted;
    for (k = 0; k < 107; k++) pending_reqs.push_back(random_req());
    while (n_accepted < base + 10) @(posedge clk);
    long_hold_req = 1'b1;
    while (pending_reqs.size() > 0 || req_ch.valid) @(posedge clk);

    while (expected_fires.size() > 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (expected_fires.size() > 0) begin
      $display("%0t: expiries never reported: expected 0 left, actual %0d left",
               $time, expected_fires.size());
    end

    $display("Covered %0d requests: %0d ticks and %0d program or cancel requests.",
             n_accepted, n_ticks, n_programs);
    $display("Checked %0d expiry results under three backpressure mixes; %0d errors.",
             n_fires, errors);
    if (errors == 0 && expected_fires.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
